// File: hw/rtl/kcs_pkg.sv
// Shared constants and types for the keyed columnar substitution block.
`timescale 1ns / 1ps
`default_nettype none

package kcs_pkg;

  // Alphabet and key geometry
  localparam int AlphaSize  = 26;
  localparam int LetterW    = 5;
  localparam int KeyMax     = 26;
  localparam int KeyVecW    = 130;
  localparam int CharW      = 8;
  localparam int StepW      = 6;

  // Register widths and indexes
  localparam int CfgDataW   = 60;
  localparam int CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegKeyLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyMid  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyLen  = 3'd3;

  localparam logic [CharW-1:0] CharFirst = 8'h41;  // 'A'

  typedef logic [LetterW-1:0] letter_t;

  // Build sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DEDUP    = 7'b0000010,
    ST_REST     = 7'b0000100,
    ST_IDENT    = 7'b0001000,
    ST_COL_SCAN = 7'b0010000,
    ST_COL_READ = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

endpackage : kcs_pkg

`default_nettype wire

// File: hw/rtl/kcs_in_if.sv
// Input channel: one message byte per item.
`timescale 1ns / 1ps
`default_nettype none

interface kcs_in_if
  import kcs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] plain_char;

  modport source (output valid, output plain_char, input ready);
  modport sink   (input valid, input plain_char, output ready);
endinterface : kcs_in_if

`default_nettype wire

// File: hw/rtl/kcs_out_if.sv
// Result channel: one substituted byte per item.
`timescale 1ns / 1ps
`default_nettype none

interface kcs_out_if
  import kcs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] cipher_char;

  modport source (output valid, output cipher_char, input ready);
  modport sink   (input valid, input cipher_char, output ready);
endinterface : kcs_out_if

`default_nettype wire

// File: hw/rtl/keyed_columnar_substitution.sv
// Keyed columnar substitution: key registers, table build sequencer and lookup.
//
// Takes message bytes and returns one byte per item: 'A'..'Z' are replaced by
// the keyed columnar substitution of the letter, every other byte passes
// unchanged. While the table is valid and the output is not stalled an item is
// accepted every cycle and its result appears in the output register on the next
// edge. The first item after reset or after any write to a key register starts a
// table build run by a small sequencer: it scans the given key letters (up to
// 26) and removes duplicates, then writes the identity table (no usable key
// letter) or lists the unused letters, then, for a keyed table, reads out the
// columns in the order of their head letters, each walked down the remaining
// letters, and at last delivers the result for the held item, waiting while the
// output is stalled.
// The block accepts nothing during a build. Key registers may only be written
// while the block is idle; a write to an index above 3 is ignored.
`timescale 1ns / 1ps
`default_nettype none

module keyed_columnar_substitution
  import kcs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  kcs_in_if.sink                   in_ch,
  kcs_out_if.source                out_ch
);

  localparam logic [LetterW-1:0] LastLetter = LetterW'(AlphaSize - 1);
  localparam logic [LetterW-1:0] KeyMaxW    = LetterW'(KeyMax);

  // Key registers
  logic [CfgDataW-1:0]     key_low_r, key_mid_r;
  logic [2*LetterW-1:0]    key_high_r;
  logic [LetterW-1:0]      key_len_r;
  logic                    table_valid_r;
  logic                    cfg_hit;

  // Sequencer and working storage
  state_t                  state_r, state_nxt;
  logic [LetterW-1:0]      cnt_r, cnt_nxt;
  logic [LetterW-1:0]      width_r, width_nxt;
  logic [LetterW-1:0]      nrest_r, nrest_nxt;
  logic [LetterW-1:0]      pos_r, pos_nxt;
  logic [StepW-1:0]        m_r, m_nxt;
  logic [AlphaSize-1:0]    used_r, used_nxt;
  letter_t                 col_of_r [AlphaSize];
  letter_t                 rest_r   [AlphaSize];
  letter_t                 tbl_r    [AlphaSize];
  logic [CharW-1:0]        char_r;

  // Write strobes into the working arrays
  logic                    col_we, rest_we, tbl_we;
  letter_t                 tbl_waddr, tbl_wdata;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [CharW-1:0]        out_char_r, out_char_nxt;
  logic                    out_free;

  // Shared datapath terms
  logic [KeyVecW-1:0]      key_vec;
  letter_t                 cur_letter;
  logic                    letter_ok, letter_new;
  logic [LetterW-1:0]      key_len_eff;
  logic                    in_fire;
  logic                    set_valid;

  // Lookup of a byte in the current table
  logic [CharW-1:0]        look_char, look_ofs, look_res;
  logic                    look_is_letter;

  assign cfg_hit = cfg_we && (cfg_index == RegKeyLow || cfg_index == RegKeyMid ||
                              cfg_index == RegKeyHigh || cfg_index == RegKeyLen);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_mid_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= LetterW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKeyLow:  key_low_r  <= cfg_data;
        RegKeyMid:  key_mid_r  <= cfg_data;
        RegKeyHigh: key_high_r <= cfg_data[2*LetterW-1:0];
        RegKeyLen:  key_len_r  <= cfg_data[LetterW-1:0];
        default: ;
      endcase
    end
  end

  assign key_vec     = {key_high_r, key_mid_r, key_low_r};
  assign cur_letter  = key_vec[LetterW*cnt_r +: LetterW];
  assign letter_ok   = (cur_letter < LetterW'(AlphaSize));
  assign letter_new  = letter_ok && !used_r[cur_letter];
  assign key_len_eff = (key_len_r > KeyMaxW) ? KeyMaxW : key_len_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Table lookup, used for a direct hit and at the end of a build
  assign look_char      = (state_r == ST_IDLE) ? in_ch.plain_char : char_r;
  assign look_ofs       = look_char - CharFirst;
  assign look_is_letter = (look_char >= CharFirst) && (look_ofs < CharW'(AlphaSize));
  assign look_res       = look_is_letter ?
                          (CharFirst + CharW'(tbl_r[look_ofs[LetterW-1:0]])) : look_char;

  // Build sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    width_nxt     = width_r;
    nrest_nxt     = nrest_r;
    pos_nxt       = pos_r;
    m_nxt         = m_r;
    used_nxt      = used_r;
    col_we        = 1'b0;
    rest_we       = 1'b0;
    tbl_we        = 1'b0;
    tbl_waddr     = pos_r;
    tbl_wdata     = cnt_r;
    set_valid     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (table_valid_r) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = look_res;
          end else begin
            cnt_nxt   = '0;
            width_nxt = '0;
            used_nxt  = '0;
            state_nxt = ST_DEDUP;
          end
        end
      end
      // one key letter per cycle, first occurrences only
      ST_DEDUP: begin
        if (cnt_r < key_len_eff) begin
          if (letter_new) begin
            used_nxt[cur_letter] = 1'b1;
            col_we    = 1'b1;
            width_nxt = width_r + 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = '0;
          nrest_nxt = '0;
          state_nxt = (width_r == '0) ? ST_IDENT : ST_REST;
        end
      end
      // no usable key letter: identity table
      ST_IDENT: begin
        tbl_we    = 1'b1;
        tbl_waddr = cnt_r;
        tbl_wdata = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LastLetter) begin
          state_nxt = ST_FINISH;
        end
      end
      // list the letters not in the key
      ST_REST: begin
        if (!used_r[cnt_r]) begin
          rest_we   = 1'b1;
          nrest_nxt = nrest_r + 1'b1;
        end
        if (cnt_r == LastLetter) begin
          cnt_nxt   = '0;
          pos_nxt   = '0;
          state_nxt = ST_COL_SCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // columns in alphabetical order of their head letter
      ST_COL_SCAN: begin
        if (used_r[cnt_r]) begin
          tbl_we    = 1'b1;
          tbl_wdata = cnt_r;
          pos_nxt   = pos_r + 1'b1;
          m_nxt     = {1'b0, col_of_r[cnt_r]};
          state_nxt = ST_COL_READ;
        end else if (cnt_r == LastLetter) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // walk down one column of the remaining letters
      ST_COL_READ: begin
        if (m_r < {1'b0, nrest_r}) begin
          tbl_we    = 1'b1;
          tbl_wdata = rest_r[m_r[LetterW-1:0]];
          pos_nxt   = pos_r + 1'b1;
          m_nxt     = m_r + {1'b0, width_r};
        end else if (cnt_r == LastLetter) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_COL_SCAN;
        end
      end
      // table complete: deliver the held item
      ST_FINISH: begin
        if (out_free) begin
          set_valid     = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = look_res;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      table_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_hit) begin
        table_valid_r <= 1'b0;
      end else if (set_valid) begin
        table_valid_r <= 1'b1;
      end
    end
  end

  // Working registers and tables
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    width_r    <= width_nxt;
    nrest_r    <= nrest_nxt;
    pos_r      <= pos_nxt;
    m_r        <= m_nxt;
    used_r     <= used_nxt;
    out_char_r <= out_char_nxt;
    if (in_fire) begin
      char_r <= in_ch.plain_char;
    end
    if (col_we) begin
      col_of_r[cur_letter] <= width_r;
    end
    if (rest_we) begin
      rest_r[nrest_r] <= cnt_r;
    end
    if (tbl_we) begin
      tbl_r[tbl_waddr] <= tbl_wdata;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cipher_char = out_char_r;

  // Checks
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == ST_IDLE))
    else $error("input ready outside idle");

  a_tbl_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (tbl_waddr < LetterW'(AlphaSize)))
    else $error("table write beyond alphabet");

  a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEDUP) |-> (width_r <= cnt_r))
    else $error("key width exceeds letters scanned");

  a_build_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free && !cfg_hit) |=> (table_valid_r && out_valid_r))
    else $error("build end did not validate table and deliver");

endmodule : keyed_columnar_substitution

`default_nettype wire
